[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SKIT_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define SKIT_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define SKIT_ASSERT_ALWAYS(label, ant, cons) \
    label: assert property (@(posedge aclk) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/skit_pkg.sv]
// Shared types and constants of the sorted key insertion table.
// No dependencies.
package skit_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 16;
    localparam int INDEX_W  = 6;
    localparam int TOTAL_W  = 7;
    localparam int REQ_W    = 3;
    localparam int DATA_W   = 40;
    localparam int S_USER_W = REQ_W;
    localparam int M_USER_W = 1;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUBBLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    typedef struct packed {
        logic        [HANDLE_W-1:0] handle;
        logic signed [KEY_W-1:0]    key;
    } entry_t;

    localparam int ENTRY_W = HANDLE_W + KEY_W;

endpackage

[design/sorted_key_insertion_table.sv]
// Sorted key insertion table: top level with control sequencer.
// Depends on skit_pkg and skit_ram.
//
// Usage:
//   Input channel s_*: s_tuser holds the request code (append, sorted insert,
//   bubble pass, read, clear), s_tdata the handle, key and read index.
//   Result channel m_*: one item per request; m_tuser holds ok, m_tdata the
//   entry total and, for a successful read, the handle and key.
//   Entries live in one RAM with one write and one registered read port.
//   Sorted insert and bubble pass stream the table through the RAM read port
//   one entry a cycle. One request is handled at a time: s_tready rises at
//   the edge that loads the result, also while it waits there.
//   Reset empties the table at once (entry count to zero); RAM contents are
//   not cleared and are never read before being written.
//   A stalled receiver holds the result in the output register; the next
//   request runs and then waits until that register is free.
module sorted_key_insertion_table #(
    parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // handle[15:0], sort_key[31:16], read_index[37:32], zero pad
    input  logic [skit_pkg::DATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [skit_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_total[6:0], out_handle[22:7], out_key[38:23], zero pad
    output logic [skit_pkg::DATA_W-1:0]   m_tdata,
    // ok[0]
    output logic [skit_pkg::M_USER_W-1:0] m_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > skit_pkg::INDEX_W) ? CW : skit_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_BUB,
        S_RD,
        S_OUT
    } state_t;

    state_t                              state_reg, state_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [CW-1:0]                       rd_ptr_reg, rd_ptr_next;
    logic                                pend_reg, pend_next;
    logic [AW-1:0]                       pend_addr_reg, pend_addr_next;
    logic                                ins_reg, ins_next;
    skit_pkg::entry_t                    carry_reg, carry_next;
    skit_pkg::entry_t                    new_reg, new_next;
    logic                                res_ok_reg, res_ok_next;
    logic [skit_pkg::HANDLE_W-1:0]       res_h_reg, res_h_next;
    logic [skit_pkg::KEY_W-1:0]          res_k_reg, res_k_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [skit_pkg::DATA_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [skit_pkg::M_USER_W-1:0]       m_tuser_reg, m_tuser_next;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr, ram_raddr;
    skit_pkg::entry_t                    ram_wdata, ram_rdata;

    logic [skit_pkg::REQ_W-1:0]          in_req;
    skit_pkg::entry_t                    in_entry;
    logic [skit_pkg::INDEX_W-1:0]        in_idx;
    logic [IW-1:0]                       idx_ext, count_ext;
    logic                                has_room, swap;

    skit_ram #(
        .WIDTH (skit_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_req          = s_tuser[skit_pkg::REQ_W-1:0];
    assign in_entry.handle = s_tdata[15:0];
    assign in_entry.key    = s_tdata[31:16];
    assign in_idx          = s_tdata[37:32];
    assign idx_ext         = IW'(in_idx);
    assign count_ext       = IW'(count_reg);
    assign has_room        = (count_reg < CW'(CAPACITY));
    assign swap = (carry_reg.handle != '0) && (ram_rdata.handle != '0) &&
                  (ram_rdata.key < carry_reg.key);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        ins_next       = ins_reg;
        carry_next     = carry_reg;
        new_next       = new_reg;
        res_ok_next    = res_ok_reg;
        res_h_next     = res_h_reg;
        res_k_next     = res_k_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = rd_ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    new_next    = in_entry;
                    res_ok_next = 1'b0;
                    res_h_next  = '0;
                    res_k_next  = '0;
                    rd_ptr_next = '0;
                    pend_next   = 1'b0;
                    ins_next    = 1'b0;
                    state_next  = S_OUT;
                    case (in_req)
                        skit_pkg::REQ_APPEND: begin
                            if (has_room) begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[AW-1:0];
                                ram_wdata   = in_entry;
                                count_next  = count_reg + CW'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        skit_pkg::REQ_INSERT: begin
                            if (has_room) begin
                                state_next = S_INS;
                            end
                        end
                        skit_pkg::REQ_BUBBLE: begin
                            state_next = S_BUB;
                        end
                        skit_pkg::REQ_READ: begin
                            if (idx_ext < count_ext && idx_ext < IW'(CAPACITY)) begin
                                ram_raddr  = AW'(in_idx);
                                state_next = S_RD;
                            end
                        end
                        skit_pkg::REQ_CLEAR: begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                        end
                        default: begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD: begin
                res_ok_next = 1'b1;
                res_h_next  = ram_rdata.handle;
                res_k_next  = ram_rdata.key;
                state_next  = S_OUT;
            end
            S_INS: begin
                if (pend_reg) begin
                    if (ins_reg) begin
                        ram_we     = 1'b1;
                        ram_waddr  = pend_addr_reg;
                        ram_wdata  = carry_reg;
                        carry_next = ram_rdata;
                    end else if (ram_rdata.handle != '0 && new_reg.key < ram_rdata.key) begin
                        ram_we     = 1'b1;
                        ram_waddr  = pend_addr_reg;
                        ram_wdata  = new_reg;
                        carry_next = ram_rdata;
                        ins_next   = 1'b1;
                    end
                end
                if (rd_ptr_reg < count_reg) begin
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg[AW-1:0];
                    rd_ptr_next    = rd_ptr_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && rd_ptr_reg >= count_reg) begin
                    ram_we      = 1'b1;
                    ram_waddr   = count_reg[AW-1:0];
                    ram_wdata   = ins_reg ? carry_reg : new_reg;
                    count_next  = count_reg + CW'(1);
                    res_ok_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_BUB: begin
                if (pend_reg) begin
                    if (pend_addr_reg == '0) begin
                        carry_next = ram_rdata;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = pend_addr_reg - AW'(1);
                        ram_wdata  = swap ? ram_rdata : carry_reg;
                        carry_next = swap ? carry_reg : ram_rdata;
                    end
                end
                if (rd_ptr_reg < count_reg) begin
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg[AW-1:0];
                    rd_ptr_next    = rd_ptr_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && rd_ptr_reg >= count_reg) begin
                    if (count_reg != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(count_reg - CW'(1));
                        ram_wdata = carry_reg;
                    end
                    res_ok_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_k_reg, res_h_reg,
                                     skit_pkg::TOTAL_W'(count_reg)};
                    m_tuser_next  = res_ok_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        ins_reg       <= ins_next;
        carry_reg     <= carry_next;
        new_reg       <= new_next;
        res_ok_reg    <= res_ok_next;
        res_h_reg     <= res_h_next;
        res_k_reg     <= res_k_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

[design/skit_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/skit_checker.sv]
// Port-level checker for the sorted key insertion table, bound to the top level.
// Depends on skit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skit_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [skit_pkg::DATA_W-1:0]   m_tdata,
    input logic [skit_pkg::M_USER_W-1:0] m_tuser
);

    logic in_fire;

    assign in_fire = s_tvalid && s_tready;

    `SKIT_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SKIT_ASSERT_NOW(a_fail_no_payload, m_tvalid && !m_tuser[0], m_tdata[38:7] == '0)
    `SKIT_ASSERT_NEXT(a_one_at_a_time, in_fire, !s_tready)
    `SKIT_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind sorted_key_insertion_table skit_checker u_skit_checker (.*);
